// ----- sv/led_strip_frame_shifter_macros.svh -----
// ----------------------------------------------------------------------------
// LED strip frame shifter assertion macros
// Shared concurrent assertion forms, clocked on i_clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef LED_STRIP_FRAME_SHIFTER_MACROS_SVH
`define LED_STRIP_FRAME_SHIFTER_MACROS_SVH

// Same-cycle implication.
`define LSFS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LSFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/lsfs_pkg.sv -----
// ----------------------------------------------------------------------------
// lsfs_pkg
// Types and constants shared by the LED strip frame shifter modules.
// ----------------------------------------------------------------------------
package lsfs_pkg;

    // Default frame store size in pixels.
    localparam int MAX_PIXELS_DEF = 64;

    // Fixed field widths.
    localparam int COLOUR_W = 8;
    localparam int INDEX_W  = 8;
    localparam int ACTIVE_W = 7;
    localparam int ROW_W    = 3 * COLOUR_W;

    // Pixel count register value after reset.
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 7'd64;

    // Colour byte positions within a pixel, in output order.
    localparam logic [1:0] COL_RED   = 2'd0;
    localparam logic [1:0] COL_GREEN = 2'd1;
    localparam logic [1:0] COL_BLUE  = 2'd2;

    // Result kind codes.
    localparam logic RES_READ = 1'b0;
    localparam logic RES_BIT  = 1'b1;

    // Input item kinds.
    typedef enum logic [1:0] {
        KIND_WRITE   = 2'd0,
        KIND_READ    = 2'd1,
        KIND_REFRESH = 2'd2,
        KIND_TICK    = 2'd3
    } t_kind;

    // Controller states.
    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_RESULT = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic do_write;
        logic do_read;
        logic do_refresh;
        logic do_tick;
        logic do_load;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic busy;
        logic out_free;
    } t_dp_status;

endpackage

// ----- sv/lsfs_ctrl.sv -----
// ----------------------------------------------------------------------------
// lsfs_ctrl
// Controller: accepts input transactions and sequences the store lookup
// and the load of the output register.
// ----------------------------------------------------------------------------
module lsfs_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  lsfs_pkg::t_kind       i_kind,
    input  lsfs_pkg::t_dp_status  i_status,
    output logic                  o_in_ready,
    output lsfs_pkg::t_ctrl_cmd   o_cmd
);
    import lsfs_pkg::*;
    `include "led_strip_frame_shifter_macros.svh"

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_kind)
                        KIND_WRITE: begin
                            o_cmd.do_write = 1'b1;
                        end
                        KIND_READ: begin
                            o_cmd.do_read = 1'b1;
                            n_state       = ST_RESULT;
                        end
                        KIND_REFRESH: begin
                            o_cmd.do_refresh = 1'b1;
                        end
                        KIND_TICK: begin
                            o_cmd.do_tick = 1'b1;
                            if (i_status.busy) begin
                                n_state = ST_RESULT;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.do_load = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // A read always takes the controller to its result state in the next cycle.
    `LSFS_ASSERT_NEXT(a_read_to_result, o_cmd.do_read, r_state == ST_RESULT, "read lost result")
    // An idle tick gives no result and keeps the controller idle.
    `LSFS_ASSERT_NEXT(a_idle_tick, o_cmd.do_tick && !i_status.busy, r_state == ST_IDLE, "idle tick")
    // The output register is loaded only when it can take the result.
    `LSFS_ASSERT_NOW(a_load_free, o_cmd.do_load, i_status.out_free, "load over full output")

endmodule

// ----- sv/lsfs_datapath.sv -----
// ----------------------------------------------------------------------------
// lsfs_datapath
// Frame store, refresh pointers, pixel count register and output register.
// ----------------------------------------------------------------------------
module lsfs_datapath #(
    parameter int MAX_PIXELS = lsfs_pkg::MAX_PIXELS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lsfs_pkg::t_ctrl_cmd               i_cmd,
    output lsfs_pkg::t_dp_status              o_status,
    input  logic                              i_cfg_wr_en,
    input  logic [lsfs_pkg::ACTIVE_W-1:0]     i_cfg_wr_data,
    input  logic [lsfs_pkg::INDEX_W-1:0]      i_pixel_index,
    input  logic [lsfs_pkg::COLOUR_W-1:0]     i_red_in,
    input  logic [lsfs_pkg::COLOUR_W-1:0]     i_green_in,
    input  logic [lsfs_pkg::COLOUR_W-1:0]     i_blue_in,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_result_kind,
    output logic [lsfs_pkg::COLOUR_W-1:0]     o_red_out,
    output logic [lsfs_pkg::COLOUR_W-1:0]     o_green_out,
    output logic [lsfs_pkg::COLOUR_W-1:0]     o_blue_out,
    output logic                              o_index_valid,
    output logic                              o_data_bit,
    output logic                              o_last_bit
);
    import lsfs_pkg::*;
    `include "led_strip_frame_shifter_macros.svh"

    localparam int PIX_W  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
    localparam int BYTE_W = $clog2(3 * MAX_PIXELS + 1);

    // Frame store: one row of red, green, blue per pixel.
    logic [ROW_W-1:0]      r_colour_mem [MAX_PIXELS];
    logic [MAX_PIXELS-1:0] r_row_valid;
    logic [ROW_W-1:0]      r_rd_data;
    logic                  r_row_hit;

    // Configuration and refresh state.
    logic [ACTIVE_W-1:0]   r_active;
    logic                  r_busy;
    logic [PIX_W-1:0]      r_pix_ptr;
    logic [1:0]            r_col_ptr;
    logic [2:0]            r_bit_ptr;

    // Captured item context for the result cycle.
    logic                  r_res_kind;
    logic                  r_in_range;
    logic [1:0]            r_sel_col;
    logic [2:0]            r_sel_bit;
    logic                  r_res_last;

    // Output register.
    logic                  r_out_valid;
    logic                  r_out_kind;
    logic [COLOUR_W-1:0]   r_out_red;
    logic [COLOUR_W-1:0]   r_out_green;
    logic [COLOUR_W-1:0]   r_out_blue;
    logic                  r_out_index_valid;
    logic                  r_out_data_bit;
    logic                  r_out_last;

    logic [CNT_W-1:0]      count;
    logic [BYTE_W-1:0]     frame_bytes;
    logic [BYTE_W-1:0]     byte_next;
    logic                  idx_in_range;
    logic [PIX_W-1:0]      idx_row;
    logic                  tick_go;
    logic                  tick_last;
    logic                  rd_en;
    logic [PIX_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [ROW_W-1:0]      row_data;
    logic [COLOUR_W-1:0]   sel_byte;

    // Effective pixel count and frame length in bytes.
    always_comb begin
        if (r_active < ACTIVE_W'(MAX_PIXELS)) begin
            count = CNT_W'(r_active);
        end else begin
            count = CNT_W'(MAX_PIXELS);
        end
        frame_bytes = (BYTE_W'(count) << 1) + BYTE_W'(count);
        byte_next   = (BYTE_W'(r_pix_ptr) << 1) + BYTE_W'(r_pix_ptr)
                    + BYTE_W'(r_col_ptr) + BYTE_W'(1);
    end

    // Index decode and store port control.
    always_comb begin
        idx_in_range = i_pixel_index < INDEX_W'(count);
        idx_row      = i_pixel_index[PIX_W-1:0];
        tick_go      = i_cmd.do_tick && r_busy;
        tick_last    = (r_bit_ptr == 3'd0) && (byte_next >= frame_bytes);
        wr_en        = i_cmd.do_write && idx_in_range;
        rd_en        = tick_go || (i_cmd.do_read && idx_in_range);
        rd_addr      = i_cmd.do_read ? idx_row : r_pix_ptr;
    end

    // Store write port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_colour_mem[idx_row] <= {i_red_in, i_green_in, i_blue_in};
        end
    end

    // Store read port with registered data.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_colour_mem[rd_addr];
        end
    end

    // Row valid bits; a row never written reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_row_hit   <= 1'b0;
        end else begin
            if (wr_en) begin
                r_row_valid[idx_row] <= 1'b1;
            end
            if (rd_en) begin
                r_row_hit <= r_row_valid[rd_addr];
            end
        end
    end

    // Pixel count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
        end else if (i_cfg_wr_en) begin
            r_active <= i_cfg_wr_data;
        end
    end

    // Refresh pointers: byte by byte, each byte MSB first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_pix_ptr <= '0;
            r_col_ptr <= COL_RED;
            r_bit_ptr <= 3'd7;
        end else if (i_cmd.do_refresh) begin
            r_busy    <= (count != '0);
            r_pix_ptr <= '0;
            r_col_ptr <= COL_RED;
            r_bit_ptr <= 3'd7;
        end else if (tick_go) begin
            if (r_bit_ptr == 3'd0) begin
                r_bit_ptr <= 3'd7;
                if (tick_last) begin
                    r_busy    <= 1'b0;
                    r_pix_ptr <= '0;
                    r_col_ptr <= COL_RED;
                end else if (r_col_ptr == COL_BLUE) begin
                    r_col_ptr <= COL_RED;
                    r_pix_ptr <= r_pix_ptr + PIX_W'(1);
                end else begin
                    r_col_ptr <= r_col_ptr + 2'd1;
                end
            end else begin
                r_bit_ptr <= r_bit_ptr - 3'd1;
            end
        end
    end

    // Item context captured when the lookup starts.
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_read) begin
            r_res_kind <= RES_READ;
            r_in_range <= idx_in_range;
            r_sel_col  <= COL_RED;
            r_sel_bit  <= 3'd7;
            r_res_last <= 1'b0;
        end else if (tick_go) begin
            r_res_kind <= RES_BIT;
            r_in_range <= 1'b1;
            r_sel_col  <= r_col_ptr;
            r_sel_bit  <= r_bit_ptr;
            r_res_last <= tick_last;
        end
    end

    // Looked-up row and the colour byte being shifted out.
    always_comb begin
        row_data = r_row_hit ? r_rd_data : '0;
        case (r_sel_col)
            COL_RED:   sel_byte = row_data[3*COLOUR_W-1:2*COLOUR_W];
            COL_GREEN: sel_byte = row_data[2*COLOUR_W-1:COLOUR_W];
            COL_BLUE:  sel_byte = row_data[COLOUR_W-1:0];
            default:   sel_byte = '0;
        endcase
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.do_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_load) begin
            r_out_kind <= r_res_kind;
            if (r_res_kind == RES_READ) begin
                r_out_red         <= r_in_range ? row_data[3*COLOUR_W-1:2*COLOUR_W] : '0;
                r_out_green       <= r_in_range ? row_data[2*COLOUR_W-1:COLOUR_W] : '0;
                r_out_blue        <= r_in_range ? row_data[COLOUR_W-1:0] : '0;
                r_out_index_valid <= r_in_range;
                r_out_data_bit    <= 1'b0;
                r_out_last        <= 1'b0;
            end else begin
                r_out_red         <= '0;
                r_out_green       <= '0;
                r_out_blue        <= '0;
                r_out_index_valid <= 1'b0;
                r_out_data_bit    <= sel_byte[r_sel_bit];
                r_out_last        <= r_res_last;
            end
        end
    end

    assign o_status.busy     = r_busy;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_red_out     = r_out_red;
    assign o_green_out   = r_out_green;
    assign o_blue_out    = r_out_blue;
    assign o_index_valid = r_out_index_valid;
    assign o_data_bit    = r_out_data_bit;
    assign o_last_bit    = r_out_last;

    // A refresh with no pixels in use leaves the shifter idle.
    `LSFS_ASSERT_NEXT(a_empty_refresh, i_cmd.do_refresh && count == '0, !r_busy, "empty refresh")
    // The final bit of a frame ends the refresh and rewinds the pointers.
    `LSFS_ASSERT_NEXT(a_frame_end, tick_go && tick_last && !i_cmd.do_refresh, !r_busy && r_pix_ptr == '0, "frame end")
    // The pixel pointer never leaves the frame store.
    `LSFS_ASSERT_NOW(a_ptr_range, r_busy, {1'b0, r_pix_ptr} < (PIX_W+1)'(MAX_PIXELS), "pointer range")

endmodule

// ----- sv/led_strip_frame_shifter.sv -----
// ----------------------------------------------------------------------------
// led_strip_frame_shifter
// RGB LED strip frame store with pixel read/write and a serial refresh
// shifter that gives one data bit per tick transaction while a refresh is busy.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  in        input      i_in_valid / o_in_ready   kind, pixel index, red/green/blue
//  out       output     o_out_valid / i_out_ready result kind, colours, flags
//  cfg       input      i_cfg_wr_en               active pixel count (7 bits)
//
// Write, refresh and idle tick transactions leave the controller idle.
// Read and busy tick transactions pass through the registered frame store
// read and then the result state, which loads the output register.
// A full output register that is not being drained holds the block in its
// result cycle; the input side is taken again once the result is loaded.
// Synchronous reset clears all row valid bits together; no clearing pass.
// ----------------------------------------------------------------------------
module led_strip_frame_shifter #(
    parameter int MAX_PIXELS = lsfs_pkg::MAX_PIXELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [lsfs_pkg::ACTIVE_W-1:0]  i_cfg_wr_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_kind,
    input  logic [lsfs_pkg::INDEX_W-1:0]   i_pixel_index,
    input  logic [lsfs_pkg::COLOUR_W-1:0]  i_red_in,
    input  logic [lsfs_pkg::COLOUR_W-1:0]  i_green_in,
    input  logic [lsfs_pkg::COLOUR_W-1:0]  i_blue_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_result_kind,
    output logic [lsfs_pkg::COLOUR_W-1:0]  o_red_out,
    output logic [lsfs_pkg::COLOUR_W-1:0]  o_green_out,
    output logic [lsfs_pkg::COLOUR_W-1:0]  o_blue_out,
    output logic                           o_index_valid,
    output logic                           o_data_bit,
    output logic                           o_last_bit
);
    import lsfs_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // Controller.
    lsfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (t_kind'(i_kind)),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // Datapath.
    lsfs_datapath #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_pixel_index (i_pixel_index),
        .i_red_in      (i_red_in),
        .i_green_in    (i_green_in),
        .i_blue_in     (i_blue_in),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_result_kind (o_result_kind),
        .o_red_out     (o_red_out),
        .o_green_out   (o_green_out),
        .o_blue_out    (o_blue_out),
        .o_index_valid (o_index_valid),
        .o_data_bit    (o_data_bit),
        .o_last_bit    (o_last_bit)
    );

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// LED strip frame shifter testbench
// Drives pixel write, read, refresh and tick transactions with random idling
// on both channels, and checks every result against a cycle-free model of the
// frame store and serial shifter kept inside the testbench.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lsfs_pkg::*;

    localparam int STRIP_PIXELS     = MAX_PIXELS_DEF;
    localparam int STORE_BYTES      = 3 * STRIP_PIXELS;
    localparam int RANDOM_ITEMS     = 1300;
    localparam int SETTLE_CYCLES    = 6;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int MAX_REPORTS      = 10;

    // One input transaction.
    typedef struct packed {
        t_kind                kind;
        logic [INDEX_W-1:0]   index;
        logic [ROW_W-1:0]     colour;
    } t_strip_cmd;

    // One output transaction.
    typedef struct packed {
        logic                res_kind;
        logic [COLOUR_W-1:0] red;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] blue;
        logic                idx_ok;
        logic                data_bit;
        logic                last_bit;
    } t_strip_readout;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_cfg_wr_en    = 1'b0;
    logic [ACTIVE_W-1:0] i_cfg_wr_data  = '0;
    logic                i_in_valid     = 1'b0;
    logic                o_in_ready;
    logic [1:0]          i_kind         = KIND_WRITE;
    logic [INDEX_W-1:0]  i_pixel_index  = '0;
    logic [COLOUR_W-1:0] i_red_in       = '0;
    logic [COLOUR_W-1:0] i_green_in     = '0;
    logic [COLOUR_W-1:0] i_blue_in      = '0;
    logic                o_out_valid;
    logic                i_out_ready    = 1'b0;
    logic                o_result_kind;
    logic [COLOUR_W-1:0] o_red_out;
    logic [COLOUR_W-1:0] o_green_out;
    logic [COLOUR_W-1:0] o_blue_out;
    logic                o_index_valid;
    logic                o_data_bit;
    logic                o_last_bit;

    // Stimulus and expectation stores.
    t_strip_cmd     pending_cmds[$];
    t_strip_readout pending_readouts[$];
    int             queued_count   = 0;
    int             mismatch_count = 0;

    // Idling controls, set per phase by the sequencer.
    bit sender_gaps_on  = 1'b0;
    bit recv_stalls_on  = 1'b0;
    bit long_hold_req   = 1'b0;
    bit long_hold_done  = 1'b0;
    int send_gap        = 0;
    int recv_stall      = 0;

    // Model state: frame store, shifter pointers and the pixel count register.
    logic [COLOUR_W-1:0] frame_store[STORE_BYTES];
    bit                  shift_busy   = 1'b0;
    int unsigned         shift_byte   = 0;
    int unsigned         shift_bit    = 7;
    logic [ACTIVE_W-1:0] model_active = ACTIVE_RESET;

    led_strip_frame_shifter #(
        .MAX_PIXELS(STRIP_PIXELS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_kind(i_kind),
        .i_pixel_index(i_pixel_index),
        .i_red_in(i_red_in),
        .i_green_in(i_green_in),
        .i_blue_in(i_blue_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_result_kind(o_result_kind),
        .o_red_out(o_red_out),
        .o_green_out(o_green_out),
        .o_blue_out(o_blue_out),
        .o_index_valid(o_index_valid),
        .o_data_bit(o_data_bit),
        .o_last_bit(o_last_bit)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Applies one accepted transaction to the model and records its result.
    function automatic void strip_model_step(t_kind kind, logic [INDEX_W-1:0] index,
                                             logic [ROW_W-1:0] colour);
        int unsigned    pixels;
        int unsigned    frame_len;
        int unsigned    idx;
        int unsigned    base;
        int unsigned    pos;
        t_strip_readout res;
        pixels    = (int'(model_active) < STRIP_PIXELS) ? int'(model_active) : STRIP_PIXELS;
        frame_len = pixels * 3;
        idx       = int'(index);
        base      = idx * 3;
        res       = '0;
        case (kind)
            KIND_WRITE: begin
                if (idx < pixels) begin
                    frame_store[base + COL_RED]   = colour[23:16];
                    frame_store[base + COL_GREEN] = colour[15:8];
                    frame_store[base + COL_BLUE]  = colour[7:0];
                end
            end
            KIND_READ: begin
                res.res_kind = RES_READ;
                if (idx < pixels) begin
                    res.red    = frame_store[base + COL_RED];
                    res.green  = frame_store[base + COL_GREEN];
                    res.blue   = frame_store[base + COL_BLUE];
                    res.idx_ok = 1'b1;
                end
                pending_readouts.push_back(res);
            end
            KIND_REFRESH: begin
                shift_byte = 0;
                shift_bit  = 7;
                shift_busy = (frame_len != 0);
            end
            KIND_TICK: begin
                if (shift_busy) begin
                    pos          = (shift_byte < STORE_BYTES) ? shift_byte : STORE_BYTES - 1;
                    res.res_kind = RES_BIT;
                    res.data_bit = frame_store[pos][shift_bit];
                    // The frame ends on bit 0 of a byte at or past the current length.
                    if (shift_bit == 0) begin
                        if (shift_byte + 1 >= frame_len) begin
                            res.last_bit = 1'b1;
                            shift_busy   = 1'b0;
                            shift_byte   = 0;
                        end else begin
                            shift_byte = shift_byte + 1;
                        end
                        shift_bit = 7;
                    end else begin
                        shift_bit = shift_bit - 1;
                    end
                    pending_readouts.push_back(res);
                end
            end
            default: ;
        endcase
    endfunction

    // Compares one output transaction with the oldest expectation.
    task automatic check_readout();
        t_strip_readout got;
        t_strip_readout want;
        string          bad;
        got  = '{o_result_kind, o_red_out, o_green_out, o_blue_out,
                 o_index_valid, o_data_bit, o_last_bit};
        want = '0;
        bad  = "";
        if (pending_readouts.size() == 0) begin
            bad = " (no result expected)";
        end else begin
            want = pending_readouts.pop_front();
            if (got.res_kind !== want.res_kind) bad = {bad, " result_kind"};
            if (got.red      !== want.red)      bad = {bad, " red_out"};
            if (got.green    !== want.green)    bad = {bad, " green_out"};
            if (got.blue     !== want.blue)     bad = {bad, " blue_out"};
            if (got.idx_ok   !== want.idx_ok)   bad = {bad, " index_valid"};
            if (got.data_bit !== want.data_bit) bad = {bad, " data_bit"};
            if (got.last_bit !== want.last_bit) bad = {bad, " last_bit"};
        end
        if (bad != "") begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $display({"%0t: readout error%s: expected kind=%0d rgb=%h/%h/%h",
                          " ok=%0d bit=%0d last=%0d"},
                         $realtime, bad, want.res_kind, want.red, want.green, want.blue,
                         want.idx_ok, want.data_bit, want.last_bit);
                $display("%0t:   got kind=%0d rgb=%h/%h/%h ok=%0d bit=%0d last=%0d",
                         $realtime, got.res_kind, got.red, got.green, got.blue,
                         got.idx_ok, got.data_bit, got.last_bit);
            end
        end
    endtask

    // Driver: offers queued transactions and feeds each accepted one to the model.
    always @(posedge i_clk) begin
        t_strip_cmd cmd;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                strip_model_step(t_kind'(i_kind), i_pixel_index,
                                 {i_red_in, i_green_in, i_blue_in});
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap != 0) begin
                    send_gap   <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    cmd = pending_cmds.pop_front();
                    i_kind        <= cmd.kind;
                    i_pixel_index <= cmd.index;
                    i_red_in      <= cmd.colour[23:16];
                    i_green_in    <= cmd.colour[15:8];
                    i_blue_in     <= cmd.colour[7:0];
                    i_in_valid    <= 1'b1;
                    send_gap      <= sender_gaps_on ? pick_gap() : 0;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks results and stalls the output side.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_stall  <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                check_readout();
            end
            if (long_hold_req && !long_hold_done) begin
                long_hold_done <= 1'b1;
                recv_stall     <= LONG_HOLD_CYCLES;
                i_out_ready    <= 1'b0;
            end else if (recv_stall != 0) begin
                recv_stall  <= recv_stall - 1;
                i_out_ready <= 1'b0;
            end else if (recv_stalls_on && $urandom_range(0, 3) == 0) begin
                recv_stall  <= pick_gap();
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic push_cmd(input t_kind kind, input int index, input logic [ROW_W-1:0] colour);
        t_strip_cmd cmd;
        cmd.kind   = kind;
        cmd.index  = index[INDEX_W-1:0];
        cmd.colour = colour;
        pending_cmds.push_back(cmd);
        queued_count++;
    endtask

    // Waits until every transaction is accepted and every result has arrived.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_cmds.size() != 0 || i_in_valid || pending_readouts.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_active(input logic [ACTIVE_W-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        model_active = value;
    endtask

    // Mostly indexes inside the used part of the strip, some anywhere.
    function automatic int pick_index(int pixels);
        if (pixels > 0 && $urandom_range(0, 99) < 85) begin
            return $urandom_range(0, pixels - 1);
        end
        return $urandom_range(0, 255);
    endfunction

    // A well-formed session: fill some pixels, read back, then shift a frame
    // out with occasional writes, reads, restarts and stray kinds mixed in.
    task automatic queue_session(input int pixels, input int tick_cap);
        int ticks;
        int roll;
        repeat ($urandom_range(1, 8)) push_cmd(KIND_WRITE, pick_index(pixels), ROW_W'($urandom));
        repeat ($urandom_range(1, 4)) push_cmd(KIND_READ, pick_index(pixels), ROW_W'($urandom));
        push_cmd(KIND_REFRESH, $urandom_range(0, 255), ROW_W'($urandom));
        ticks = pixels * 24 + $urandom_range(0, 3);
        if (ticks > tick_cap) ticks = tick_cap;
        for (int n = 0; n < ticks; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                push_cmd(KIND_WRITE, pick_index(pixels), ROW_W'($urandom));
            end else if (roll < 8) begin
                push_cmd(KIND_READ, pick_index(pixels), ROW_W'($urandom));
            end else if (roll == 8) begin
                push_cmd(KIND_REFRESH, $urandom_range(0, 255), ROW_W'($urandom));
            end else if (roll == 9) begin
                push_cmd(t_kind'($urandom_range(0, 3)), $urandom_range(0, 255),
                         ROW_W'($urandom));
            end
            push_cmd(KIND_TICK, $urandom_range(0, 255), ROW_W'($urandom));
        end
    endtask

    // Sequencer: reset, directed checks, then randomized phases.
    initial begin
        int                  phase;
        int                  random_base;
        int                  pixels;
        int                  roll;
        logic [ACTIVE_W-1:0] active;
        for (int n = 0; n < STORE_BYTES; n++) frame_store[n] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Cleared store read at both ends of the range and past it; idle tick.
        push_cmd(KIND_READ, 0, ROW_W'($urandom));
        push_cmd(KIND_READ, 63, ROW_W'($urandom));
        push_cmd(KIND_READ, 64, ROW_W'($urandom));
        push_cmd(KIND_READ, 255, ROW_W'($urandom));
        push_cmd(KIND_TICK, 0, ROW_W'($urandom));
        // Writes at the ends of the range; out-of-range writes are dropped.
        push_cmd(KIND_WRITE, 0, 24'hFF00A5);
        push_cmd(KIND_WRITE, 63, 24'h00FF5A);
        push_cmd(KIND_WRITE, 64, 24'h112233);
        push_cmd(KIND_WRITE, 255, 24'hFFFFFF);
        push_cmd(KIND_READ, 0, ROW_W'($urandom));
        push_cmd(KIND_READ, 63, ROW_W'($urandom));
        push_cmd(KIND_READ, 64, ROW_W'($urandom));
        // First byte out, then a refresh while busy restarts the frame.
        push_cmd(KIND_REFRESH, 0, ROW_W'($urandom));
        repeat (8) push_cmd(KIND_TICK, 0, ROW_W'($urandom));
        push_cmd(KIND_REFRESH, 0, ROW_W'($urandom));
        repeat (3) push_cmd(KIND_TICK, 0, ROW_W'($urandom));
        wait_drained();

        // Randomized phases, each starting once the previous one has drained.
        random_base = queued_count;
        phase       = 0;
        while (queued_count - random_base < RANDOM_ITEMS) begin
            case (phase)
                0: active = 7'd0;
                1: active = 7'd1;
                2: active = 7'd64;
                3: active = 7'd127;
                default: begin
                    roll = $urandom_range(0, 99);
                    if (roll < 70)      active = ACTIVE_W'($urandom_range(1, 6));
                    else if (roll < 80) active = ACTIVE_W'($urandom_range(7, 20));
                    else if (roll < 87) active = 7'd0;
                    else if (roll < 93) active = 7'd64;
                    else                active = ACTIVE_W'($urandom_range(65, 127));
                end
            endcase
            write_active(active);
            pixels = (int'(active) < STRIP_PIXELS) ? int'(active) : STRIP_PIXELS;
            roll   = $urandom_range(0, 3);
            sender_gaps_on = (roll != 0) && ($urandom_range(0, 2) != 0);
            recv_stalls_on = (roll != 0) && ($urandom_range(0, 2) != 0);
            if (phase == 2) begin
                // Output held off while reads keep coming, so the input stalls.
                sender_gaps_on = 1'b0;
                long_hold_req  = 1'b1;
                repeat (40) push_cmd(KIND_READ, pick_index(pixels), ROW_W'($urandom));
            end
            queue_session(pixels, (pixels > 12) ? 200 : 1000);
            wait_drained();
            phase++;
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("led_strip_frame_shifter: match");
        end else begin
            $display("led_strip_frame_shifter: mismatch");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #4_000_000;
        $display("led_strip_frame_shifter: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/lsfs_pkg.sv
sv/lsfs_ctrl.sv
sv/lsfs_datapath.sv
sv/led_strip_frame_shifter.sv
tb/sv/tb.sv
